// File: hw/rtl/gelut_pkg.sv
// Shared types and fixed-point constants for the tanh-form GELU pipeline.
package gelut_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int IQ         = 28;
	localparam int EXP_TERMS  = 12;

	localparam logic [28:0] ONE        = 29'h1000_0000;
	localparam logic [27:0] K0_Q       = 28'd214180519;
	localparam logic [23:0] K1_Q       = 24'd12003091;
	localparam logic [27:0] LN2_Q      = 28'd186065280;
	localparam logic [12:0] RCP_LN2    = 13'((64'd1 << 40) / 64'd186065280);
	localparam int          RCP_SHIFT  = 24;
	localparam logic [6:0]  EXP_CUTOFF = 7'd40;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] x_in;
		logic                         last_in;
	} act_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] y_out;
		logic                         last_out;
	} res_t;

	typedef struct packed {
		logic                         neg;
		logic                         big;
		logic                         last;
		logic signed [DATA_WIDTH-1:0] x;
	} side_t;

	typedef struct packed {
		side_t       side;
		logic [30:0] a;
		logic [6:0]  n;
		logic [27:0] r;
		logic [28:0] term;
		logic [28:0] sum;
	} exp_t;

endpackage

// File: hw/rtl/gelut_term.sv
// One series term of exp(-r): multiply by r, divide by the term index, accumulate.
module gelut_term #(
	parameter int K = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gelut_pkg::exp_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gelut_pkg::exp_t  out_data
);

	localparam logic [32:0] RCP      = 33'((64'd1 << 32) / K);
	localparam logic [3:0]  KD       = 4'(K);
	localparam bit          ADD_PREV = ((K - 1) % 2) == 0;

	logic            v_s1, v_s2, v_s3;
	logic            en_s1, en_s2, en_s3;
	gelut_pkg::exp_t c_s1, c_s2, c_s3;
	gelut_pkg::exp_t c_d1, c_d3;
	logic [56:0]     prod_s1;
	logic [27:0]     p_s2;
	logic [60:0]     pm_s2;
	logic [27:0]     qe;
	logic [31:0]     qk;
	logic [31:0]     rem;

	assign en_s3    = ~v_s3 | out_ready;
	assign en_s2    = ~v_s2 | en_s3;
	assign en_s1    = ~v_s1 | en_s2;
	assign in_ready = en_s1;

	assign qe  = pm_s2[59:32];
	assign qk  = 32'(qe) * 32'(KD);
	assign rem = 32'(p_s2) - qk;

	always_comb begin
		c_d1      = in_data;
		c_d1.sum  = ADD_PREV ? in_data.sum + in_data.term : in_data.sum - in_data.term;
		c_d3      = c_s2;
		c_d3.term = 29'(qe) + 29'(rem >= 32'(K));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1    <= c_d1;
			prod_s1 <= 57'(in_data.term) * 57'(in_data.r);
		end
		if (en_s2) begin
			c_s2  <= c_s1;
			p_s2  <= prod_s1[55:28];
			pm_s2 <= 61'(prod_s1[55:28]) * 61'(RCP);
		end
		if (en_s3) begin
			c_s3 <= c_d3;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = c_s3;

endmodule

// File: hw/rtl/gelut_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gelut_div #(
	parameter int QB = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [QB+29:0]     num,
	input  logic [29:0]        den,
	input  gelut_pkg::side_t   in_side,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [QB-1:0]      quo,
	output gelut_pkg::side_t   out_side
);

	localparam int RW = 30;

	logic             vld_s  [1:QB];
	logic             rdy    [0:QB];
	logic [QB-1:0]    lq_s   [1:QB];
	gelut_pkg::side_t side_s [1:QB];
	logic [RW-1:0]    rem_s  [1:QB-1];
	logic [RW-1:0]    den_s  [1:QB-1];

	assign rdy[QB]  = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic             v_in;
		logic [QB-1:0]    q_in;
		logic [RW-1:0]    r_in;
		logic [RW-1:0]    d_in;
		gelut_pkg::side_t s_in;
		logic [RW:0]      t;
		logic [RW:0]      diff;

		if (k == 0) begin : g_head
			assign v_in = in_valid;
			assign q_in = num[QB-1:0];
			assign r_in = num[QB+RW-1:QB];
			assign d_in = den;
			assign s_in = in_side;
		end else begin : g_body
			assign v_in = vld_s[k];
			assign q_in = lq_s[k];
			assign r_in = rem_s[k];
			assign d_in = den_s[k];
			assign s_in = side_s[k];
		end

		assign t      = {r_in, q_in[QB-1]};
		assign diff   = t - {1'b0, d_in};
		assign rdy[k] = ~vld_s[k+1] | rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				lq_s[k+1]   <= {q_in[QB-2:0], ~diff[RW]};
				side_s[k+1] <= s_in;
			end
		end

		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					rem_s[k+1] <= diff[RW] ? t[RW-1:0] : diff[RW-1:0];
					den_s[k+1] <= d_in;
				end
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quo       = lq_s[QB];
	assign out_side  = side_s[QB];

endmodule

// File: hw/rtl/gelu_tanh_forward.sv
// Top level of the tanh-form GELU pipeline on Q4.12 activations.
//
//   beat      handshake               payload
//   act       act_valid / act_ready   act_data  {x_in, last_in}
//   res       res_valid / res_ready   res_data  {y_out, last_out}
//
// One beat per clock sustained while res_ready stays high. Data passes the front
// stages, the 12-term exp series, s13-s16, the divider and an output register.
// arst_n clears every valid bit; payload registers are not reset.
// Each stage holds while its successor is full and stalled; bubbles are filled.
module gelu_tanh_forward #(
	parameter int FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              act_valid,
	output logic              act_ready,
	input  gelut_pkg::act_t   act_data,
	output logic              res_valid,
	input  logic              res_ready,
	output gelut_pkg::res_t   res_data
);

	localparam int DW = gelut_pkg::DATA_WIDTH;
	localparam int SH = gelut_pkg::IQ - FRAC_BITS;
	localparam int QB = FRAC_BITS + 3;
	localparam int NW = QB + 30;
	localparam int NF = 12;
	localparam int NT = gelut_pkg::EXP_TERMS;

	logic [DW:0]      mag;
	logic             sgn;
	logic             big;

	logic [NF:1]      fv_s;
	logic [NF:1]      fen;
	gelut_pkg::side_t side_s [1:NF];
	logic [30:0]      a_s    [1:NF];

	logic [61:0]      a2p_s2;
	logic [33:0]      a2_s3;
	logic [57:0]      tp_s4;
	logic [30:0]      opt_s5;
	logic [61:0]      vp_s6;
	logic [32:0]      v_s7;
	logic [60:0]      zp_s8;
	logic [33:0]      w_s9, w_s10, w_s11;
	logic [30:0]      qp_s10;
	logic [6:0]       ne;
	logic [6:0]       ne_s11;
	logic [34:0]      nl_s11, nl1_s11;
	logic [35:0]      r0, r1;
	logic [6:0]       n_s12;
	logic [27:0]      r_s12;

	logic             tv [0:NT];
	logic             tr [0:NT];
	gelut_pkg::exp_t  tc [0:NT];

	logic             v_s13, v_s14, v_s15, v_s16;
	logic             en_s13, en_s14, en_s15, en_s16;
	gelut_pkg::side_t side_s13, side_s14, side_s15, side_s16;
	logic [30:0]      a_s13, a_s14;
	logic [6:0]       n_s13;
	logic [28:0]      sum_s13;
	logic [28:0]      e_s14;
	logic [59:0]      mp_s15;
	logic [29:0]      den_s15, den_s16;
	logic [NW-1:0]    nn_s16;

	logic             div_rdy;
	logic             dv;
	logic [QB-1:0]    dq;
	gelut_pkg::side_t dside;
	logic             en_out;
	logic             res_v_q;
	gelut_pkg::res_t  res_q;
	logic [DW-1:0]    ymag;

	assign sgn = act_data.x_in[DW-1];
	assign mag = sgn ? ((DW+1)'(0) - {act_data.x_in[DW-1], act_data.x_in})
	                 : {1'b0, act_data.x_in};
	assign big = 32'(mag) >= (32'd8 << FRAC_BITS);

	always_comb begin
		fen[NF] = ~fv_s[NF] | tr[0];
		for (int k = NF - 1; k >= 1; k--) begin
			fen[k] = ~fv_s[k] | fen[k+1];
		end
	end
	assign act_ready = fen[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s <= '0;
		end else begin
			if (fen[1]) fv_s[1] <= act_valid;
			for (int k = 2; k <= NF; k++) begin
				if (fen[k]) fv_s[k] <= fv_s[k-1];
			end
		end
	end

	assign ne = 7'(qp_s10 >> gelut_pkg::RCP_SHIFT);
	assign r0 = 36'(w_s11) - 36'(nl_s11);
	assign r1 = 36'(w_s11) - 36'(nl1_s11);

	always_ff @(posedge clk) begin
		if (fen[1]) begin
			side_s[1] <= '{neg: sgn, big: big, last: act_data.last_in, x: act_data.x_in};
			a_s[1]    <= 31'(32'(mag) << SH);
		end
		for (int k = 2; k <= NF; k++) begin
			if (fen[k]) begin
				side_s[k] <= side_s[k-1];
				a_s[k]    <= a_s[k-1];
			end
		end
		if (fen[2])  a2p_s2 <= 62'(a_s[1]) * 62'(a_s[1]);
		if (fen[3])  a2_s3  <= 34'(a2p_s2 >> 28) + 34'(a2p_s2[27]);
		if (fen[4])  tp_s4  <= 58'(gelut_pkg::K1_Q) * 58'(a2_s3);
		if (fen[5])  opt_s5 <= 31'(gelut_pkg::ONE) + 31'(tp_s4 >> 28) + 31'(tp_s4[27]);
		if (fen[6])  vp_s6  <= 62'(a_s[5]) * 62'(opt_s5);
		if (fen[7])  v_s7   <= 33'(vp_s6 >> 28) + 33'(vp_s6[27]);
		if (fen[8])  zp_s8  <= 61'(gelut_pkg::K0_Q) * 61'(v_s7);
		if (fen[9])  w_s9   <= {33'(zp_s8 >> 28) + 33'(zp_s8[27]), 1'b0};
		if (fen[10]) begin
			qp_s10 <= 31'(w_s9 >> 16) * 31'(gelut_pkg::RCP_LN2);
			w_s10  <= w_s9;
		end
		if (fen[11]) begin
			ne_s11  <= ne;
			nl_s11  <= 35'(ne) * 35'(gelut_pkg::LN2_Q);
			nl1_s11 <= 35'(8'(ne) + 8'd1) * 35'(gelut_pkg::LN2_Q);
			w_s11   <= w_s10;
		end
		if (fen[12]) begin
			if (!r1[35]) begin
				n_s12 <= ne_s11 + 7'd1;
				r_s12 <= r1[27:0];
			end else begin
				n_s12 <= ne_s11;
				r_s12 <= r0[27:0];
			end
		end
	end

	assign tv[0] = fv_s[NF];
	assign tc[0] = '{side: side_s[NF], a: a_s[NF], n: n_s12, r: r_s12,
	                 term: gelut_pkg::ONE, sum: '0};

	for (genvar g = 0; g < NT; g++) begin : g_term
		gelut_term #(
			.K(g + 1)
		) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (tv[g]),
			.in_ready  (tr[g]),
			.in_data   (tc[g]),
			.out_valid (tv[g+1]),
			.out_ready (tr[g+1]),
			.out_data  (tc[g+1])
		);
	end

	assign en_s16 = ~v_s16 | div_rdy;
	assign en_s15 = ~v_s15 | en_s16;
	assign en_s14 = ~v_s14 | en_s15;
	assign en_s13 = ~v_s13 | en_s14;
	assign tr[NT] = en_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else begin
			if (en_s13) v_s13 <= tv[NT];
			if (en_s14) v_s14 <= v_s13;
			if (en_s15) v_s15 <= v_s14;
			if (en_s16) v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s13) begin
			side_s13 <= tc[NT].side;
			a_s13    <= tc[NT].a;
			n_s13    <= tc[NT].n;
			sum_s13  <= tc[NT].sum + tc[NT].term;
		end
		if (en_s14) begin
			side_s14 <= side_s13;
			a_s14    <= a_s13;
			e_s14    <= (n_s13 >= gelut_pkg::EXP_CUTOFF) ? '0 : sum_s13 >> n_s13;
		end
		if (en_s15) begin
			side_s15 <= side_s14;
			mp_s15   <= 60'(a_s14) * 60'(side_s14.neg ? e_s14 : gelut_pkg::ONE);
			den_s15  <= 30'(gelut_pkg::ONE) + 30'(e_s14);
		end
		if (en_s16) begin
			side_s16 <= side_s15;
			den_s16  <= den_s15;
			nn_s16   <= NW'((61'(mp_s15) + (61'(den_s15) << (SH - 1))) >> SH);
		end
	end

	gelut_div #(
		.QB(QB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s16),
		.in_ready  (div_rdy),
		.num       (nn_s16),
		.den       (den_s16),
		.in_side   (side_s16),
		.out_valid (dv),
		.out_ready (en_out),
		.quo       (dq),
		.out_side  (dside)
	);

	assign en_out = ~res_v_q | res_ready;
	assign ymag   = DW'(dq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en_out) begin
			res_v_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q.last_out <= dside.last;
			if (dside.big) begin
				res_q.y_out <= dside.neg ? '0 : dside.x;
			end else begin
				res_q.y_out <= dside.neg ? DW'(0) - ymag : ymag;
			end
		end
	end

	assign res_valid = res_v_q;
	assign res_data  = res_q;

endmodule
